// ===== hdl/sbe_pkg.sv =====
// Package with opcode, error and state encodings of the stack bytecode executor.
`default_nettype none
package sbe_pkg;

  typedef enum logic [4:0] {
    OP_PUSHINT = 5'd0, OP_PUSHBOOL = 5'd1, OP_LOAD = 5'd2, OP_STORE = 5'd3,
    OP_ADD = 5'd4, OP_SUB = 5'd5, OP_MUL = 5'd6, OP_DIV = 5'd7,
    OP_EQ = 5'd8, OP_NEQ = 5'd9, OP_LT = 5'd10, OP_GT = 5'd11,
    OP_LTE = 5'd12, OP_GTE = 5'd13, OP_PRINT = 5'd14, OP_INPUT = 5'd15,
    OP_JUMP = 5'd16, OP_JUMPFALSE = 5'd17, OP_POP = 5'd18, OP_HALT = 5'd19
  } op_t;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0, ERR_UNDERFLOW = 3'd1, ERR_UNDEF = 3'd2,
    ERR_DIVZERO = 3'd3, ERR_BADOP = 3'd4, ERR_OVERFLOW = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_OUT
  } state_t;

  localparam logic [1:0] START_NONE = 2'd0;

  // Request to the divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/sbe_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module sbe_div #(
  parameter int W = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire sbe_pkg::div_ctl_t     ctl,
  input  wire logic [W-1:0]          dividend,
  input  wire logic [W-1:0]          divisor,
  output logic                       done,
  output logic [W-1:0]               quotient
);
  import sbe_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; dsr_nxt = dsr_r; cnt_nxt = cnt_r;
    neg_nxt = neg_r; busy_nxt = busy_r; done_nxt = 1'b0;
    shifted = {rem_r[W-1:0], q_r[W-1]};
    trial = shifted - {1'b0, dsr_r};
    if (ctl.start) begin
      q_nxt = dividend[W-1] ? (~dividend + 1'b1) : dividend;
      dsr_nxt = divisor[W-1] ? (~divisor + 1'b1) : divisor;
      neg_nxt = dividend[W-1] ^ divisor[W-1];
      rem_nxt = '0;
      cnt_nxt = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial;
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; rem_r <= rem_nxt; dsr_r <= dsr_nxt; neg_r <= neg_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
  end

  assign done = done_r;
  assign quotient = neg_r ? (~q_r + 1'b1) : q_r;

  busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> busy_r) else $error("divider did not start");
  done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");

endmodule
`default_nettype wire

// ===== hdl/stack_bytecode_executor_core.sv =====
// Top level of the stack bytecode executor: control, stack and variable memories.
`default_nettype none
// One instruction is taken per input transaction and gives one result
// transaction. The operand stack and the variable store are synchronous
// memories inside this module. The accepting edge reads the top two stack
// entries and the addressed variable, and the next cycle executes and writes
// back. A simple instruction then goes from ST_EXEC straight to ST_OUT, where
// its result is on the output. A division runs on a bit-serial divider in
// ST_DIV before ST_OUT. A new instruction is accepted only in the cycle
// after the current result has been taken, so a receiver that holds off
// delays the next instruction. Multiplication is a single DATA_WIDTH
// product. A variable defined bit lives in flip-flops so that clearing all
// variables is immediate; the stack contents are never read above the
// count, so no clearing pass is needed. in_tdata fields, from bit 0:
// imm_value, var_index, input_value, pc; in_tuser: start_req, op.
// out_tdata: next_pc, print_value, error; out_tuser: halted, print_valid,
// print_is_bool.
module stack_bytecode_executor_core #(
  parameter int STACK_DEPTH = 64,
  parameter int VAR_SLOTS   = 32,
  parameter int DATA_WIDTH  = 32,
  parameter int PC_WIDTH    = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // imm_value[31:0], var_index[36:32], input_value[68:37], pc[84:69], zero pad
  input  wire logic [87:0]  in_tdata,
  // start_req[1:0], op[6:2]
  input  wire logic [6:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // next_pc[15:0], print_value[47:16], error[50:48], zero pad
  output logic [55:0]       out_tdata,
  // halted[0], print_valid[1], print_is_bool[2]
  output logic [2:0]        out_tuser
);
  import sbe_pkg::*;

  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int VAW = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;
  localparam int CELLW = DATA_WIDTH + 1;

  // Memories: cell = {is_bool, value}.
  logic [CELLW-1:0] stk_mem [STACK_DEPTH];
  logic [CELLW-1:0] var_mem [VAR_SLOTS];
  logic [CELLW-1:0] rd_a_r, rd_b_r, rd_v_r;

  state_t state_r, state_nxt;
  logic [SCW-1:0] cnt_r, cnt_nxt;
  logic [VAR_SLOTS-1:0] def_r, def_nxt;

  // Latched instruction.
  logic [1:0] start_r;
  logic [4:0] op_r;
  logic [31:0] imm_r, inp_r;
  logic [4:0] vi_r;
  logic [15:0] pc_r;

  // Result register.
  logic [15:0] npc_r, npc_nxt;
  logic halt_r, halt_nxt, pv_r, pv_nxt, pb_r, pb_nxt;
  logic [31:0] pval_r, pval_nxt;
  logic [2:0] err_r, err_nxt;

  // Write ports and stack read addresses.
  logic sw_en; logic [SAW-1:0] sw_addr; logic [CELLW-1:0] sw_data;
  logic vw_en; logic [VAW-1:0] vw_addr; logic [CELLW-1:0] vw_data;
  logic [SAW-1:0] ra_addr, rb_addr;

  div_ctl_t dctl;
  logic div_done;
  logic [DATA_WIDTH-1:0] div_q;

  // Effective count after the start request.
  logic [SCW-1:0] ecnt;
  logic slot_ok;
  logic [VAW-1:0] slot;
  logic [DATA_WIDTH-1:0] immd, inpd, av, bv;
  logic ab, bb;
  logic [PC_WIDTH-1:0] pcinc;
  logic slt_ab, slt_ba, eqv;
  logic [DATA_WIDTH-1:0] alu;
  logic signed [DATA_WIDTH-1:0] sprd;

  assign ecnt = (start_r != START_NONE) ? '0 : cnt_r;
  assign slot_ok = ({27'd0, vi_r} < 32'(VAR_SLOTS));
  assign slot = slot_ok ? VAW'(vi_r) : '0;
  assign immd = DATA_WIDTH'($signed(imm_r));
  assign inpd = DATA_WIDTH'($signed(inp_r));
  assign {ab, av} = rd_a_r;
  assign {bb, bv} = rd_b_r;
  assign pcinc = PC_WIDTH'(pc_r) + 1'b1;
  assign slt_ab = $signed(av) < $signed(bv);
  assign slt_ba = $signed(bv) < $signed(av);
  assign eqv = (ab == bb) && (av == bv);
  assign sprd = $signed(rd_b_r[DATA_WIDTH-1:0]);

  // Read addresses from the counter after the incoming start request applies.
  always_comb begin
    logic [SCW-1:0] c;
    c = (in_tuser[1:0] != START_NONE) ? '0 : cnt_r;
    rb_addr = SAW'(c - 1'b1);
    ra_addr = SAW'(c - 2'd2);
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      rd_a_r <= stk_mem[ra_addr];
      rd_b_r <= stk_mem[rb_addr];
      rd_v_r <= var_mem[(in_tdata[36:32] < 5'(VAR_SLOTS > 31 ? 31 : VAR_SLOTS))
                        || VAR_SLOTS > 31 ? VAW'(in_tdata[36:32]) : '0];
    end
    if (sw_en) stk_mem[sw_addr] <= sw_data;
    if (vw_en) var_mem[vw_addr] <= vw_data;
  end

  always_comb begin
    unique case (op_r)
      OP_ADD: alu = av + bv;
      OP_SUB: alu = av - bv;
      OP_MUL: alu = DATA_WIDTH'(av * bv);
      OP_EQ:  alu = DATA_WIDTH'(eqv);
      OP_NEQ: alu = DATA_WIDTH'(!eqv);
      OP_LT:  alu = DATA_WIDTH'(slt_ab);
      OP_GT:  alu = DATA_WIDTH'(slt_ba);
      OP_LTE: alu = DATA_WIDTH'(!slt_ba);
      OP_GTE: alu = DATA_WIDTH'(!slt_ab);
      default: alu = div_q;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_EXEC;
      ST_EXEC: if (op_r == OP_DIV && ecnt >= SCW'(2) && bv != '0) state_nxt = ST_DIV;
               else state_nxt = ST_OUT;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Execution and outputs.
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_OUT);
    dctl.start = 1'b0;
    cnt_nxt = cnt_r; def_nxt = def_r;
    sw_en = 1'b0; sw_addr = '0; sw_data = '0;
    vw_en = 1'b0; vw_addr = slot; vw_data = '0;
    npc_nxt = npc_r; halt_nxt = halt_r; pv_nxt = pv_r; pb_nxt = pb_r;
    pval_nxt = pval_r; err_nxt = err_r;
    if (state_r == ST_EXEC) begin
      cnt_nxt = ecnt;
      if (start_r[1]) def_nxt = '0;
      npc_nxt = 16'(pcinc); halt_nxt = 1'b0; pv_nxt = 1'b0; pb_nxt = 1'b0;
      pval_nxt = '0; err_nxt = ERR_NONE;
      case (op_r) inside
        OP_PUSHINT, OP_PUSHBOOL, OP_LOAD: begin
          if (op_r == OP_LOAD && (!slot_ok || !def_nxt[slot])) err_nxt = ERR_UNDEF;
          else if (ecnt >= SCW'(STACK_DEPTH)) err_nxt = ERR_OVERFLOW;
          else begin
            sw_en = 1'b1; sw_addr = SAW'(ecnt);
            sw_data = (op_r == OP_PUSHINT) ? {1'b0, immd} :
                      (op_r == OP_PUSHBOOL) ? {1'b1, DATA_WIDTH'(immd != '0)} : rd_v_r;
            cnt_nxt = ecnt + 1'b1;
          end
        end
        OP_STORE: begin
          if (ecnt == '0) err_nxt = ERR_UNDERFLOW;
          else begin
            cnt_nxt = ecnt - 1'b1;
            if (slot_ok) begin
              vw_en = 1'b1; vw_data = rd_b_r; def_nxt[slot] = 1'b1;
            end
          end
        end
        [OP_ADD:OP_GTE]: begin
          if (ecnt < SCW'(2)) err_nxt = ERR_UNDERFLOW;
          else if (op_r == OP_DIV && bv == '0) err_nxt = ERR_DIVZERO;
          else if (op_r == OP_DIV) dctl.start = 1'b1;
          else begin
            sw_en = 1'b1; sw_addr = SAW'(ecnt - 2'd2);
            sw_data = {(op_r >= OP_EQ), alu}; cnt_nxt = ecnt - 1'b1;
          end
        end
        OP_PRINT: begin
          if (ecnt == '0) err_nxt = ERR_UNDERFLOW;
          else begin
            cnt_nxt = ecnt - 1'b1; pv_nxt = 1'b1; pb_nxt = bb;
            pval_nxt = 32'(sprd);
          end
        end
        OP_INPUT: if (slot_ok) begin
          vw_en = 1'b1; vw_data = {1'b0, inpd}; def_nxt[slot] = 1'b1;
        end
        OP_JUMP: npc_nxt = 16'(PC_WIDTH'(immd));
        OP_JUMPFALSE: begin
          if (ecnt == '0) err_nxt = ERR_UNDERFLOW;
          else begin
            cnt_nxt = ecnt - 1'b1;
            if (bv == '0) npc_nxt = 16'(PC_WIDTH'(immd));
          end
        end
        OP_POP: begin
          if (ecnt == '0) err_nxt = ERR_UNDERFLOW;
          else cnt_nxt = ecnt - 1'b1;
        end
        OP_HALT: halt_nxt = 1'b1;
        default: err_nxt = ERR_BADOP;
      endcase
      if (err_nxt != ERR_NONE) begin
        halt_nxt = 1'b1; npc_nxt = 16'(pcinc); pv_nxt = 1'b0; pb_nxt = 1'b0;
        pval_nxt = '0;
      end
    end else if (state_r == ST_DIV && div_done) begin
      sw_en = 1'b1; sw_addr = SAW'(cnt_r - 2'd2);
      sw_data = {1'b0, div_q}; cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      start_r <= in_tuser[1:0]; op_r <= in_tuser[6:2];
      imm_r <= in_tdata[31:0]; vi_r <= in_tdata[36:32];
      inp_r <= in_tdata[68:37]; pc_r <= in_tdata[84:69];
    end
    npc_r <= npc_nxt; pval_r <= pval_nxt;
    pb_r <= pb_nxt; pv_r <= pv_nxt; halt_r <= halt_nxt; err_r <= err_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE; cnt_r <= '0; def_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; def_r <= def_nxt;
    end
  end

  sbe_div #(.W(DATA_WIDTH)) u_div (
    .clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(av), .divisor(bv),
    .done(div_done), .quotient(div_q)
  );

  assign out_tdata = {5'd0, err_r, pval_r, npc_r};
  assign out_tuser = {pb_r, pv_r, halt_r};

  cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SCW'(STACK_DEPTH)) else $error("stack count beyond depth");
  err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && err_r != ERR_NONE |-> halt_r && !pv_r) else $error("error not halted");
  one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("accept while result pending");

endmodule
`default_nettype wire

// ===== verif/tb_stack_bytecode_executor_core.sv =====
// Self-checking testbench for the stack bytecode executor core.
`default_nettype none
module tb_stack_bytecode_executor_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sbe_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int VAR_SLOTS = 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;

  // Start request codes beyond the "nothing" code from the package.
  localparam logic [1:0] START_STACK = 2'd1;
  localparam logic [1:0] START_ALL = 2'd2;
  localparam logic [1:0] START_ALL_ALT = 2'd3;

  typedef struct packed {
    logic [1:0] start_req;
    logic [4:0] op;
    logic [31:0] imm_value;
    logic [4:0] var_index;
    logic [31:0] input_value;
    logic [15:0] pc;
  } instr_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic halted;
    logic print_valid;
    logic [31:0] print_value;
    logic print_is_bool;
    logic [2:0] error;
  } outcome_t;

  // A stack cell or variable: bool flag above a 32-bit value.
  typedef struct packed {
    logic is_bool;
    logic [31:0] val;
  } cell_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [87:0] in_tdata;
  logic [6:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [55:0] out_tdata;
  logic [2:0] out_tuser;

  stack_bytecode_executor_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // Predictor state: a private copy of the stack and the variable store.
  cell_t mdl_stack[STACK_DEPTH];
  int mdl_depth;
  cell_t mdl_vars[VAR_SLOTS];
  logic mdl_defined[VAR_SLOTS];
  // The stimulus generator keeps its own view of the depth and of defined
  // slots, so that it can shape well-formed programs.
  int gen_depth;
  logic gen_defined[VAR_SLOTS];

  instr_t pending_instrs[$];
  outcome_t expected_outcomes[$];
  int error_count = 0;
  int accepted_count = 0;
  int result_count = 0;
  int send_idle_pct = 8;
  int recv_idle_pct = 81;
  bit hold_sender = 0;
  bit stim_done = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compute the outcome of one instruction and advance the predictor state.
  function automatic outcome_t execute_instr(instr_t ins);
    outcome_t res;
    cell_t a, b, r;
    logic [2:0] err;
    logic [15:0] nxt;
    logic ok;
    err = ERR_NONE;
    nxt = ins.pc + 16'd1;
    res = '0;
    if (ins.start_req != START_NONE) mdl_depth = 0;
    if (ins.start_req[1]) for (int i = 0; i < VAR_SLOTS; i++) mdl_defined[i] = 1'b0;
    ok = ins.var_index < VAR_SLOTS;
    case (ins.op)
      OP_PUSHINT, OP_PUSHBOOL, OP_LOAD: begin
        if (ins.op == OP_PUSHINT) r = {1'b0, ins.imm_value};
        else if (ins.op == OP_PUSHBOOL) r = {1'b1, 31'd0, ins.imm_value != 0};
        else if (!ok || !mdl_defined[ins.var_index]) err = ERR_UNDEF;
        else r = mdl_vars[ins.var_index];
        if (err == ERR_NONE) begin
          if (mdl_depth >= STACK_DEPTH) err = ERR_OVERFLOW;
          else begin
            mdl_stack[mdl_depth] = r;
            mdl_depth++;
          end
        end
      end
      OP_STORE: begin
        if (mdl_depth < 1) err = ERR_UNDERFLOW;
        else begin
          mdl_depth--;
          if (ok) begin
            mdl_vars[ins.var_index] = mdl_stack[mdl_depth];
            mdl_defined[ins.var_index] = 1'b1;
          end
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NEQ, OP_LT, OP_GT, OP_LTE, OP_GTE: begin
        if (mdl_depth < 2) err = ERR_UNDERFLOW;
        else begin
          a = mdl_stack[mdl_depth - 2];
          b = mdl_stack[mdl_depth - 1];
          r = '0;
          r.is_bool = ins.op >= OP_EQ;
          case (ins.op)
            OP_ADD: r.val = a.val + b.val;
            OP_SUB: r.val = a.val - b.val;
            OP_MUL: r.val = a.val * b.val;
            OP_DIV: begin
              if (b.val == 0) err = ERR_DIVZERO;
              // Most negative over minus one wraps back to itself.
              else if (a.val == 32'h8000_0000 && b.val == 32'hFFFF_FFFF) r.val = a.val;
              else r.val = $signed(a.val) / $signed(b.val);
            end
            OP_EQ: r.val = {31'd0, a == b};
            OP_NEQ: r.val = {31'd0, a != b};
            OP_LT: r.val = {31'd0, $signed(a.val) < $signed(b.val)};
            OP_GT: r.val = {31'd0, $signed(a.val) > $signed(b.val)};
            OP_LTE: r.val = {31'd0, $signed(a.val) <= $signed(b.val)};
            default: r.val = {31'd0, $signed(a.val) >= $signed(b.val)};
          endcase
          if (err == ERR_NONE) begin
            mdl_stack[mdl_depth - 2] = r;
            mdl_depth--;
          end
        end
      end
      OP_PRINT: begin
        if (mdl_depth < 1) err = ERR_UNDERFLOW;
        else begin
          mdl_depth--;
          res.print_valid = 1'b1;
          res.print_is_bool = mdl_stack[mdl_depth].is_bool;
          res.print_value = mdl_stack[mdl_depth].val;
        end
      end
      OP_INPUT: begin
        if (ok) begin
          mdl_vars[ins.var_index] = {1'b0, ins.input_value};
          mdl_defined[ins.var_index] = 1'b1;
        end
      end
      OP_JUMP: nxt = ins.imm_value[15:0];
      OP_JUMPFALSE: begin
        if (mdl_depth < 1) err = ERR_UNDERFLOW;
        else begin
          mdl_depth--;
          if (mdl_stack[mdl_depth].val == 0) nxt = ins.imm_value[15:0];
        end
      end
      OP_POP: begin
        if (mdl_depth < 1) err = ERR_UNDERFLOW;
        else mdl_depth--;
      end
      OP_HALT: res.halted = 1'b1;
      default: err = ERR_BADOP;
    endcase
    if (err != ERR_NONE) begin
      res = '0;
      res.halted = 1'b1;
      nxt = ins.pc + 16'd1;
    end
    res.next_pc = nxt;
    res.error = err;
    return res;
  endfunction

  // Mirror of the stack depth and defined slots used only for shaping stimulus.
  task automatic track_instr(instr_t ins);
    if (ins.start_req != START_NONE) gen_depth = 0;
    if (ins.start_req[1]) for (int i = 0; i < VAR_SLOTS; i++) gen_defined[i] = 1'b0;
    case (ins.op)
      OP_PUSHINT, OP_PUSHBOOL: if (gen_depth < STACK_DEPTH) gen_depth++;
      OP_LOAD: if (gen_defined[ins.var_index] && gen_depth < STACK_DEPTH) gen_depth++;
      OP_STORE: if (gen_depth > 0) begin
        gen_depth--;
        gen_defined[ins.var_index] = 1'b1;
      end
      OP_INPUT: gen_defined[ins.var_index] = 1'b1;
      OP_PRINT, OP_JUMPFALSE, OP_POP: if (gen_depth > 0) gen_depth--;
      // Division by zero leaves the stack as it was; the generator ignores it.
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NEQ, OP_LT, OP_GT, OP_LTE, OP_GTE:
        if (gen_depth > 1) gen_depth--;
      default: ;
    endcase
  endtask

  task automatic queue_instr(logic [1:0] st, logic [4:0] op, logic [31:0] imm,
                             logic [4:0] vi, logic [31:0] inp);
    instr_t ins;
    ins.start_req = st;
    ins.op = op;
    ins.imm_value = imm;
    ins.var_index = vi;
    ins.input_value = inp;
    ins.pc = 16'($urandom);
    track_instr(ins);
    pending_instrs.insert(pending_instrs.size(), ins);
  endtask

  // Random values lean toward the extremes and small numbers so that
  // compares, wrapping and division corner cases come up often.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'd0;
      4, 5: return $urandom_range(0, 8) - 4;
      default: return $urandom;
    endcase
  endfunction

  // A well-formed instruction for the current generator depth, or noise.
  task automatic queue_random_instr();
    logic [4:0] op;
    logic [4:0] vi;
    logic [1:0] st;
    int sel;
    sel = $urandom_range(0, 99);
    vi = 5'($urandom_range(0, 7));
    st = ($urandom_range(0, 39) == 0) ? 2'($urandom_range(1, 3)) : START_NONE;
    if (sel < 8) begin
      // Noise: any opcode code, including illegal ones, any slot.
      op = 5'($urandom);
      vi = 5'($urandom);
    end else if (gen_depth < 2 || sel < 30) begin
      op = ($urandom_range(0, 3) == 0) ? OP_PUSHBOOL :
           ($urandom_range(0, 2) == 0 && gen_defined[vi]) ? OP_LOAD : OP_PUSHINT;
      if (sel > 25 && gen_depth >= STACK_DEPTH - 2) op = OP_POP;
    end else if (sel < 65) begin
      op = 5'($urandom_range(OP_ADD, OP_GTE));
    end else if (sel < 75) begin
      op = OP_PRINT;
    end else if (sel < 80) begin
      op = OP_STORE;
    end else if (sel < 84) begin
      op = OP_INPUT;
    end else if (sel < 88) begin
      op = OP_JUMPFALSE;
    end else if (sel < 92) begin
      op = OP_JUMP;
    end else if (sel < 97) begin
      op = OP_POP;
    end else begin
      op = OP_HALT;
    end
    queue_instr(st, op, pick_value(), vi, pick_value());
  endtask

  // Wait until the block has produced every expected result.
  task automatic wait_drained();
    while (pending_instrs.size() != 0 || expected_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("mismatch in result %0d: %s got %0h expected %0h",
             result_count, field, got, want);
  endtask

  // Stimulus: a directed part, then random programs under three idling mixes.
  initial begin
    rst_n = 1'b0;
    gen_depth = 0;
    mdl_depth = 0;
    for (int i = 0; i < VAR_SLOTS; i++) begin
      gen_defined[i] = 1'b0;
      mdl_defined[i] = 1'b0;
      mdl_vars[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: underflow on an empty stack, undefined load, bad opcode.
    queue_instr(START_NONE, OP_POP, 0, 0, 0);
    queue_instr(START_NONE, OP_LOAD, 0, 3, 0);
    queue_instr(START_NONE, 5'd31, 0, 0, 0);
    queue_instr(START_NONE, 5'd20, 0, 0, 0);
    // Most negative over minus one, then a division by zero.
    queue_instr(START_NONE, OP_PUSHINT, 32'h8000_0000, 0, 0);
    queue_instr(START_NONE, OP_PUSHINT, 32'hFFFF_FFFF, 0, 0);
    queue_instr(START_NONE, OP_DIV, 0, 0, 0);
    queue_instr(START_NONE, OP_PUSHINT, 0, 0, 0);
    queue_instr(START_NONE, OP_DIV, 0, 0, 0);
    queue_instr(START_NONE, OP_PRINT, 0, 0, 0);
    // Type-aware equality: a bool 1 against an int 1.
    queue_instr(START_STACK, OP_PUSHBOOL, 32'h8000_0000, 0, 0);
    queue_instr(START_NONE, OP_PUSHINT, 1, 0, 0);
    queue_instr(START_NONE, OP_EQ, 0, 0, 0);
    queue_instr(START_NONE, OP_JUMPFALSE, 32'h0001_FFFF, 0, 0);
    // Input, store and load across every slot extreme.
    queue_instr(START_NONE, OP_INPUT, 0, 31, 32'h7FFF_FFFF);
    queue_instr(START_NONE, OP_LOAD, 0, 31, 0);
    queue_instr(START_NONE, OP_STORE, 0, 0, 0);
    queue_instr(START_NONE, OP_LOAD, 0, 0, 0);
    queue_instr(START_NONE, OP_PRINT, 0, 0, 0);
    queue_instr(START_NONE, OP_JUMP, 32'hFFFF_ABCD, 0, 0);
    queue_instr(START_NONE, OP_HALT, 0, 0, 0);
    // Clearing variables makes the slot undefined again.
    queue_instr(START_ALL_ALT, OP_LOAD, 0, 31, 0);
    queue_instr(START_ALL, OP_LOAD, 0, 0, 0);
    // Fill the stack to its depth, then push once more to overflow.
    for (int i = 0; i < STACK_DEPTH; i++) queue_instr(START_NONE, OP_PUSHINT, i, 0, 0);
    queue_instr(START_NONE, OP_PUSHBOOL, 1, 0, 0);
    queue_instr(START_STACK, OP_HALT, 0, 0, 0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 81 : 0;
      recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 8 : 0;
      for (int n = 0; n < 170; n++) begin
        queue_random_instr();
        if (n == 100) begin
          // Let the queued work go out, then hold the sender off until the
          // block has answered everything.
          while (pending_instrs.size() != 0) @(posedge clk);
          hold_sender = 1'b1;
          wait_drained();
          hold_sender = 1'b0;
        end
        while (pending_instrs.size() > 8) @(posedge clk);
      end
    end
    wait_drained();
    stim_done = 1'b1;
  end

  // Driver: presents the oldest pending instruction, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_outcomes.insert(expected_outcomes.size(),
                                 execute_instr(pending_instrs.pop_front()));
        accepted_count++;
      end
      if ((!in_tvalid || in_tready) ) begin
        if (pending_instrs.size() > (in_tvalid && in_tready ? 0 : 0) && !hold_sender &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= {3'd0, pending_instrs[0].pc, pending_instrs[0].input_value,
                       pending_instrs[0].var_index, pending_instrs[0].imm_value};
          in_tuser <= {pending_instrs[0].op, pending_instrs[0].start_req};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest expectation.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        result_count++;
        if (expected_outcomes.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = expected_outcomes.pop_front();
          if (out_tdata[15:0] !== want.next_pc) report_mismatch("next_pc", out_tdata[15:0], want.next_pc);
          if (out_tdata[47:16] !== want.print_value)
            report_mismatch("print_value", out_tdata[47:16], want.print_value);
          if (out_tdata[50:48] !== want.error) report_mismatch("error", out_tdata[50:48], want.error);
          if (out_tuser[0] !== want.halted) report_mismatch("halted", out_tuser[0], want.halted);
          if (out_tuser[1] !== want.print_valid)
            report_mismatch("print_valid", out_tuser[1], want.print_valid);
          if (out_tuser[2] !== want.print_is_bool)
            report_mismatch("print_is_bool", out_tuser[2], want.print_is_bool);
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: ends the run if no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_outcomes.size());
      $display("[stack_bytecode_executor_core] ERROR");
      $finish;
    end
  end

  // End of run: let the block settle, then give the verdict.
  initial begin
    wait (stim_done);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_outcomes.size() != 0) begin
      error_count++;
      $display("%0d expected results never arrived", expected_outcomes.size());
    end
    $display("ran %0d instructions covering every opcode, errors and both clear requests,",
             accepted_count);
    $display("with %0d results checked under three idling mixes", result_count);
    if (error_count == 0) begin
      $display("[stack_bytecode_executor_core] OK");
    end else begin
      $display("[stack_bytecode_executor_core] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
